// ----- sv/hsv_to_rgb_converter_assert.svh -----
// assertion macros shared by the converter rtl
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HSV2RGB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsv2rgb check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv2rgb check failed");

`endif

// ----- sv/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    // fixed-point format of saturation and brightness
    localparam int FRAC_BITS = 16;

    // port field widths
    localparam int HUE_W  = 13;
    localparam int IN_W   = 17;
    localparam int CHAN_W = 8;

    // internal widths, derived from the fraction and port widths, but K_W and Z_W set directly
    localparam int S_W     = FRAC_BITS + 1;
    localparam int CLAMP_W = (S_W > IN_W) ? S_W : IN_W;
    localparam int K_W     = 10;
    localparam int NUM_W   = FRAC_BITS + K_W;
    localparam int SK_W    = S_W + K_W;
    localparam int PROD_W  = S_W + NUM_W;
    localparam int SCL_W   = PROD_W + CHAN_W;
    localparam int Z_W     = 12;
    localparam int Z_LSB   = 2 * FRAC_BITS + 6;

    // divide by 15 as multiply by ceil(2^16/15), exact for z below 4681
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int QP_W        = Z_W + RECIP_W;
    localparam int QUO_W       = QP_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'(4370);

    // hue geometry in 1/16 degree
    localparam int SECTOR_LEN = 960;
    localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(6 * SECTOR_LEN);
    localparam logic [K_W-1:0]   SECTOR_K = K_W'(SECTOR_LEN);

    // constants of the channel formula
    localparam logic [CLAMP_W-1:0] ONE_C    = CLAMP_W'(1) << FRAC_BITS;
    localparam logic [NUM_W-1:0]   NUM_FULL = {SECTOR_K, {FRAC_BITS{1'b0}}};
    localparam logic [CHAN_W-1:0]  CHAN_MAX = '1;

    // 60 degree sectors, named by the hue span they cover
    typedef enum logic [2:0] {
        SECT_RY = 3'd0,
        SECT_YG = 3'd1,
        SECT_GC = 3'd2,
        SECT_CB = 3'd3,
        SECT_BM = 3'd4,
        SECT_MR = 3'd5
    } sector_t;

    // stage loads driven into each channel lane
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } lane_ctl_t;

endpackage

// ----- sv/hsv2rgb_if.sv -----
// hsv item channel
interface hsv2rgb_in_if import hsv2rgb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [HUE_W-1:0]   hue;
    logic [IN_W-1:0]    saturation;
    logic [IN_W-1:0]    brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// rgb item channel
interface hsv2rgb_out_if import hsv2rgb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- sv/hsv2rgb_sector.sv -----
module hsv2rgb_sector import hsv2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             ld,
    input  logic [HUE_W-1:0] hue,
    input  logic [IN_W-1:0]  saturation,
    input  logic [IN_W-1:0]  brightness,
    output sector_t          sector,
    output logic [K_W-1:0]   k_q,
    output logic [K_W-1:0]   k_t,
    output logic [S_W-1:0]   s,
    output logic [S_W-1:0]   v
);

    sector_t            sector_reg, sector_next;
    logic [K_W-1:0]     kq_reg, kq_next;
    logic [K_W-1:0]     kt_reg, kt_next;
    logic [S_W-1:0]     s_reg, s_next;
    logic [S_W-1:0]     v_reg, v_next;
    logic [HUE_W-1:0]   hue_w;
    logic [HUE_W-1:0]   base;
    logic [CLAMP_W-1:0] s_ext;
    logic [CLAMP_W-1:0] v_ext;

    // wrap the full circle, then find sector and offset by compares
    always_comb
    begin
        hue_w = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
        if (hue_w >= HUE_W'(5 * SECTOR_LEN))
        begin
            sector_next = SECT_MR;
            base        = HUE_W'(5 * SECTOR_LEN);
        end
        else if (hue_w >= HUE_W'(4 * SECTOR_LEN))
        begin
            sector_next = SECT_BM;
            base        = HUE_W'(4 * SECTOR_LEN);
        end
        else if (hue_w >= HUE_W'(3 * SECTOR_LEN))
        begin
            sector_next = SECT_CB;
            base        = HUE_W'(3 * SECTOR_LEN);
        end
        else if (hue_w >= HUE_W'(2 * SECTOR_LEN))
        begin
            sector_next = SECT_GC;
            base        = HUE_W'(2 * SECTOR_LEN);
        end
        else if (hue_w >= HUE_W'(SECTOR_LEN))
        begin
            sector_next = SECT_YG;
            base        = HUE_W'(SECTOR_LEN);
        end
        else
        begin
            sector_next = SECT_RY;
            base        = '0;
        end
        kq_next = K_W'(hue_w - base);
        kt_next = SECTOR_K - kq_next;
    end

    // saturate both fractions at one
    always_comb
    begin
        s_ext  = CLAMP_W'(saturation);
        v_ext  = CLAMP_W'(brightness);
        s_next = S_W'((s_ext > ONE_C) ? ONE_C : s_ext);
        v_next = S_W'((v_ext > ONE_C) ? ONE_C : v_ext);
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            sector_reg <= sector_next;
            kq_reg     <= kq_next;
            kt_reg     <= kt_next;
            s_reg      <= s_next;
            v_reg      <= v_next;
        end
    end

    assign sector = sector_reg;
    assign k_q    = kq_reg;
    assign k_t    = kt_reg;
    assign s      = s_reg;
    assign v      = v_reg;

endmodule

// ----- sv/hsv2rgb_lane.sv -----
module hsv2rgb_lane import hsv2rgb_pkg::*;
(
    input  logic              clk,
    input  lane_ctl_t         ctl,
    input  logic [S_W-1:0]    s,
    input  logic [S_W-1:0]    v,
    input  logic [K_W-1:0]    k,
    output logic [CHAN_W-1:0] chan
);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [S_W-1:0]    v2_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [Z_W-1:0]    z_reg, z_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [SK_W-1:0]   sk;
    logic [SCL_W-1:0]  scaled;
    logic [QP_W-1:0]   qp;
    logic [QUO_W-1:0]  quo;

    // stage 2: numerator 960*one - s*k
    always_comb
    begin
        sk       = s * k;
        num_next = NUM_W'({1'b0, NUM_FULL} - sk);
    end

    // stage 3: v times numerator
    assign prod_next = v2_reg * num_reg;

    // stage 4: times 255, drop 2^(2F) * 64
    always_comb
    begin
        scaled = {prod_reg, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, prod_reg};
        z_next = scaled[Z_LSB +: Z_W];
    end

    // stage 5: remaining divide by 15, saturate to a channel
    always_comb
    begin
        qp        = z_reg * RECIP15;
        quo       = qp[RECIP_SHIFT +: QUO_W];
        chan_next = (quo > QUO_W'(CHAN_MAX)) ? CHAN_MAX : quo[CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            num_reg <= num_next;
            v2_reg  <= v;
        end
        if (ctl.ld3)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.ld4)
        begin
            z_reg <= z_next;
        end
        if (ctl.ld5)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// hsv_to_rgb_converter: one hsv item in, one 8-bit rgb item out, no kept state.
// channel hsv: hue in 1/16 degree (5760 and above wrap back by a full circle),
// saturation and brightness in fixed point with 65536 as 1.0, larger values
// saturate. channel rgb: red, green, blue, each floor(255 * x).
// both channels use valid/ready; an item moves when both are high.
// an accepted hsv item reaches rgb.valid through six register stages:
// sector split, numerator multiply, value multiply, scale by 255, divide by
// 15, channel select.
// throughput is one item per cycle: every stage is registered and loads in
// each cycle the pipeline moves; the multiplies sit in stages 2, 3 and 5 of
// each of the four channel lanes.
// every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver holds the result in the output
// register while earlier stages keep filling bubbles; hsv.ready drops only
// when all six stages hold items and rgb.ready is low.
// reset clears the valid bits only; no item is lost or repeated on a stall.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter import hsv2rgb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hsv2rgb_in_if.sink   hsv,
    hsv2rgb_out_if.source rgb
);

    localparam int NSTG = 6;

    logic [NSTG:1]     vld_reg, vld_next;
    logic [NSTG+1:1]   ld;
    lane_ctl_t         lane_ctl;
    sector_t           sect1;
    sector_t           sect_reg [2:5];
    logic [K_W-1:0]    k_q, k_t;
    logic [S_W-1:0]    s1, v1;
    logic [CHAN_W-1:0] ch_v, ch_p, ch_q, ch_t;
    logic [CHAN_W-1:0] red_reg, red_next;
    logic [CHAN_W-1:0] green_reg, green_next;
    logic [CHAN_W-1:0] blue_reg, blue_next;

    // a stage loads when it is empty or its successor moves
    always_comb
    begin
        ld[NSTG+1] = rgb.ready;
        for (int i = NSTG; i >= 1; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    assign lane_ctl = '{ld2: ld[2], ld3: ld[3], ld4: ld[4], ld5: ld[5]};
    assign hsv.ready = ld[1];

    // valid bits follow their items
    assign vld_next = (ld[NSTG:1] & {vld_reg[NSTG-1:1], hsv.valid})
                    | (~ld[NSTG:1] & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: sector, offsets and saturated fractions
    hsv2rgb_sector u_sector (
        .clk        (clk),
        .ld         (ld[1]),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .sector     (sect1),
        .k_q        (k_q),
        .k_t        (k_t),
        .s          (s1),
        .v          (v1)
    );

    // stages 2 to 5: one lane per candidate channel v, p, q, t
    hsv2rgb_lane u_lane_v (
        .clk  (clk),
        .ctl  (lane_ctl),
        .s    (s1),
        .v    (v1),
        .k    ('0),
        .chan (ch_v)
    );

    hsv2rgb_lane u_lane_p (
        .clk  (clk),
        .ctl  (lane_ctl),
        .s    (s1),
        .v    (v1),
        .k    (SECTOR_K),
        .chan (ch_p)
    );

    hsv2rgb_lane u_lane_q (
        .clk  (clk),
        .ctl  (lane_ctl),
        .s    (s1),
        .v    (v1),
        .k    (k_q),
        .chan (ch_q)
    );

    hsv2rgb_lane u_lane_t (
        .clk  (clk),
        .ctl  (lane_ctl),
        .s    (s1),
        .v    (v1),
        .k    (k_t),
        .chan (ch_t)
    );

    // sector travels alongside the lanes
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            sect_reg[2] <= sect1;
        end
        for (int i = 3; i <= 5; i++)
        begin
            if (ld[i])
            begin
                sect_reg[i] <= sect_reg[i-1];
            end
        end
    end

    // stage 6: pick channels by sector
    always_comb
    begin
        case (sect_reg[5])
            SECT_RY:
            begin
                red_next = ch_v; green_next = ch_t; blue_next = ch_p;
            end
            SECT_YG:
            begin
                red_next = ch_q; green_next = ch_v; blue_next = ch_p;
            end
            SECT_GC:
            begin
                red_next = ch_p; green_next = ch_v; blue_next = ch_t;
            end
            SECT_CB:
            begin
                red_next = ch_p; green_next = ch_q; blue_next = ch_v;
            end
            SECT_BM:
            begin
                red_next = ch_t; green_next = ch_p; blue_next = ch_v;
            end
            default:
            begin
                red_next = ch_v; green_next = ch_p; blue_next = ch_q;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ld[NSTG])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid = vld_reg[NSTG];
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

    // checks
    `HSV2RGB_ASSERT_NOW(a_full_blocks_input, (&vld_reg) && !rgb.ready, !hsv.ready)
    `HSV2RGB_ASSERT_NEXT(a_accept_fills_stage1, hsv.valid && hsv.ready, vld_reg[1])
    `HSV2RGB_ASSERT_NOW(a_value_is_largest, vld_reg[5],
        (ch_p <= ch_v) && (ch_q <= ch_v) && (ch_t <= ch_v))
    `HSV2RGB_ASSERT_NOW(a_out_from_stage5, $rose(rgb.valid), $past(vld_reg[5]))

endmodule

// ----- tb/hsv_to_rgb_converter_check.sv -----
module hsv_to_rgb_converter_check import hsv2rgb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    hsv2rgb_in_if   hsv,
    hsv2rgb_out_if  rgb,
    output int      errors,
    output int      outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

    // rgb items still owed by the block, oldest first
    rgb_pixel_t owed_pixels[$];

    // floor(255 * v * (ONE*960 - s*k) / (ONE*ONE*960)), capped at full scale
    function automatic logic [CHAN_W-1:0] channel_level(longint unsigned v,
                                                         longint unsigned s,
                                                         longint unsigned k);
        longint unsigned one;
        longint unsigned num;
        longint unsigned den;
        longint unsigned lvl;
        one = longint'(1) << FRAC_BITS;
        num = one * SECTOR_LEN - s * k;
        den = one * one * SECTOR_LEN;
        lvl = (longint'(CHAN_MAX) * v * num) / den;
        if (lvl > CHAN_MAX)
            return CHAN_MAX;
        return lvl[CHAN_W-1:0];
    endfunction

    // expected rgb for one hsv item
    function automatic rgb_pixel_t rgb_from_hsv(logic [HUE_W-1:0] hue,
                                                logic [IN_W-1:0]  sat,
                                                logic [IN_W-1:0]  val);
        longint unsigned one;
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned r;
        sector_t         sect;
        logic [CHAN_W-1:0] cv;
        logic [CHAN_W-1:0] cp;
        logic [CHAN_W-1:0] cq;
        logic [CHAN_W-1:0] ct;
        rgb_pixel_t      px;
        one = longint'(1) << FRAC_BITS;
        h = 64'(hue);
        s = 64'(sat);
        v = 64'(val);
        // saturate the fixed-point inputs and wrap the hue by a full circle
        if (s > one)
            s = one;
        if (v > one)
            v = one;
        if (h >= HUE_FULL)
            h = h - HUE_FULL;
        sect = sector_t'(h / SECTOR_LEN);
        r = h % SECTOR_LEN;
        cv = channel_level(v, s, 64'(0));
        cp = channel_level(v, s, 64'(SECTOR_LEN));
        cq = channel_level(v, s, r);
        ct = channel_level(v, s, 64'(SECTOR_LEN) - r);
        case (sect)
            SECT_RY: px = '{red: cv, green: ct, blue: cp};
            SECT_YG: px = '{red: cq, green: cv, blue: cp};
            SECT_GC: px = '{red: cp, green: cv, blue: ct};
            SECT_CB: px = '{red: cp, green: cq, blue: cv};
            SECT_BM: px = '{red: ct, green: cp, blue: cv};
            default: px = '{red: cv, green: cp, blue: cq};
        endcase
        return px;
    endfunction

    initial
    begin
        errors = 0;
    end

    // predict on every accepted hsv item, compare every accepted rgb item
    always @(posedge clk or negedge rst_n)
    begin
        rgb_pixel_t want;
        if (!rst_n)
        begin
            outstanding <= 0;
        end
        else
        begin
            if (hsv.valid && hsv.ready)
                owed_pixels.push_back(rgb_from_hsv(hsv.hue, hsv.saturation,
                                                   hsv.brightness));
            if (rgb.valid && rgb.ready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: rgb item %0d/%0d/%0d with none expected",
                                 $realtime, rgb.red, rgb.green, rgb.blue);
                    errors++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (rgb.red !== want.red || rgb.green !== want.green ||
                        rgb.blue !== want.blue)
                    begin
                        if (errors < 10)
                            $display("%0t: rgb expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     rgb.red, rgb.green, rgb.blue);
                        errors++;
                    end
                end
            end
            outstanding <= owed_pixels.size();
        end
    end

endmodule

// ----- tb/hsv_to_rgb_converter_test.sv -----
module hsv_to_rgb_converter_test;

    import hsv2rgb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_PIXELS = 1550;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          IDLE_PCT      = 23;
    localparam int          ONE_FX        = 1 << FRAC_BITS;
    localparam int          HUE_TOP       = (1 << HUE_W) - 1;
    localparam int          IN_TOP        = (1 << IN_W) - 1;

    logic clk;
    logic rst_n;
    logic calm;
    logic hold_req;
    int   errors;
    int   outstanding;

    hsv2rgb_in_if  hsv ();
    hsv2rgb_out_if rgb ();

    hsv_to_rgb_converter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv),
        .rgb   (rgb)
    );

    hsv_to_rgb_converter_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .hsv         (hsv),
        .rgb         (rgb),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // offer one hsv item, with random idle cycles ahead of it
    task automatic offer_pixel(int unsigned hue, int unsigned sat,
                               int unsigned val);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            hsv.valid <= 1'b0;
            @(posedge clk);
        end
        hsv.valid      <= 1'b1;
        hsv.hue        <= HUE_W'(hue);
        hsv.saturation <= IN_W'(sat);
        hsv.brightness <= IN_W'(val);
        do
            @(posedge clk);
        while (!hsv.ready);
    endtask

    // random fixed-point level, weighted toward the edges and the legal range
    function automatic int unsigned random_level();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 0;
        if (pick < 16)
            return ONE_FX;
        if (pick < 28)
            return $urandom_range(IN_TOP);
        return $urandom_range(ONE_FX);
    endfunction

    // random hue, mostly inside the circle, some at sector edges or beyond
    function automatic int unsigned random_hue();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return $urandom_range(6) * SECTOR_LEN - $urandom_range(1);
        if (pick < 20)
            return $urandom_range(HUE_TOP);
        return $urandom_range(HUE_FULL);
    endfunction

    // hsv items
    initial
    begin
        hsv.valid      <= 1'b0;
        hsv.hue        <= '0;
        hsv.saturation <= '0;
        hsv.brightness <= '0;
        calm           <= 1'b0;
        hold_req       <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);

        // sector edges at full saturation and value
        offer_pixel(0,    ONE_FX, ONE_FX);
        offer_pixel(959,  ONE_FX, ONE_FX);
        offer_pixel(960,  ONE_FX, ONE_FX);
        offer_pixel(1919, ONE_FX, ONE_FX);
        offer_pixel(1920, ONE_FX, ONE_FX);
        offer_pixel(2879, ONE_FX, ONE_FX);
        offer_pixel(2880, ONE_FX, ONE_FX);
        offer_pixel(3839, ONE_FX, ONE_FX);
        offer_pixel(3840, ONE_FX, ONE_FX);
        offer_pixel(4799, ONE_FX, ONE_FX);
        offer_pixel(4800, ONE_FX, ONE_FX);
        offer_pixel(5759, ONE_FX, ONE_FX);
        // full circle and hue beyond it
        offer_pixel(32'(HUE_FULL), ONE_FX, ONE_FX);
        offer_pixel(HUE_FULL + 1, 40000, 50000);
        offer_pixel(HUE_TOP, ONE_FX, ONE_FX);
        // zero saturation, with value at one and above one
        offer_pixel(1000, 0, ONE_FX);
        offer_pixel(3000, 0, IN_TOP);
        // saturation above one, with value at one and above one
        offer_pixel(480, IN_TOP, ONE_FX);
        offer_pixel(6000, IN_TOP, IN_TOP);
        offer_pixel(HUE_TOP, IN_TOP, IN_TOP);
        // zero value, all-zero item, tiny and just-below-one levels
        offer_pixel(2400, 32768, 0);
        offer_pixel(0, 0, 0);
        offer_pixel(100, 1, 1);
        offer_pixel(4321, ONE_FX - 1, ONE_FX - 1);

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            // long receiver hold-off while items keep coming
            if (n == 300)
                hold_req <= 1'b1;
            // stretch with no idling on either side
            if (n == 600)
                calm <= 1'b1;
            if (n == 900)
                calm <= 1'b0;
            // pause until every owed rgb item has come out
            if (n == 1100)
            begin
                hsv.valid <= 1'b0;
                do
                    @(posedge clk);
                while (outstanding != 0);
            end
            offer_pixel(random_hue(), random_level(), random_level());
        end
        hsv.valid <= 1'b0;

        // drain, then a few cycles to catch any stray rgb item
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("hsv_to_rgb_converter: match");
        else
            $display("hsv_to_rgb_converter: mismatch");
        $finish;
    end

    // rgb receiver with random stalls and one long hold-off
    initial
    begin
        rgb.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_req)
            begin
                rgb.ready <= 1'b0;
                hold_req  <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            rgb.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
        end
    end

    // run limit
    initial
    begin
        #5000000;
        $display("hsv_to_rgb_converter: mismatch");
        $finish;
    end

endmodule
